>>> rtl/mdss_pkg.sv
// shared constants, codes and address helper for the midi drum step sequencer
// no dependencies
package mdss_pkg;

	localparam int CHANNELS = 4;
	localparam int STEPS    = 16;

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CNT_W   = $clog2(CHANNELS + 1);
	localparam int DEPTH   = CHANNELS * STEPS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// midi message constants
	localparam logic [7:0] ST_NOTE_ON  = 8'h99;
	localparam logic [7:0] ST_NOTE_OFF = 8'h89;
	localparam logic [6:0] KEY_BASE    = 7'h20;
	localparam logic [7:0] STEP_OFF    = 8'hFF;

	// input function codes
	localparam logic [1:0] FN_TICK     = 2'd0;
	localparam logic [1:0] FN_PLAY     = 2'd1;
	localparam logic [1:0] FN_PRESS    = 2'd2;
	localparam logic [1:0] FN_SET_END  = 2'd3;

	// preset selector codes
	localparam logic [2:0] SEL_TOGGLE  = 3'd0;
	localparam logic [2:0] SEL_PRESET_A = 3'd1;
	localparam logic [2:0] SEL_PRESET_D = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_PRESET_A = 2'd0;
	localparam logic [1:0] REG_PRESET_B = 2'd1;
	localparam logic [1:0] REG_PRESET_C = 2'd2;
	localparam logic [1:0] REG_PRESET_D = 2'd3;

	// play mode codes
	localparam logic [1:0] PM_STOPPED = 2'd0;
	localparam logic [1:0] PM_ARMED   = 2'd1;
	localparam logic [1:0] PM_RUNNING = 2'd3;

	// flat pattern address of a channel row and step column
	function automatic logic [ADDR_W-1:0] pat_addr(input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] pos);
		pat_addr = ADDR_W'(ADDR_W'(ch) * ADDR_W'(STEPS) + ADDR_W'(pos));
	endfunction

endpackage

>>> rtl/midi_drum_step_sequencer.sv
// top level of the midi drum step sequencer: pattern memory, channel walker
// and message output register; depends on mdss_pkg
//
// usage
//   events enter on start/func/channel/column/preset_sel/midi_ready and are
//   taken at a clock edge with start high and busy low. preset velocities are
//   written through cfg_valid/cfg_ready/cfg_addr/cfg_data (always ready).
//   each midi message leaves on status_byte/note_key/note_velocity/last for
//   exactly one cycle with strobe high; last marks the final message of an
//   event. the receiver cannot stall, so messages leave at most one per cycle.
// timing
//   set end, play start and preset loads finish at the accepting edge and
//   leave busy low. a step toggle is a read-modify-write of the pattern
//   memory: busy stays high through the toggle state, where the inverse is
//   written. ticks and stop walk the channels one per cycle through the
//   single registered memory read port and the shared advance compare; each
//   message passes the registered read, a held-back pending register and the
//   output register, and the final one leaves after busy has fallen.
// reset
//   arst_n clears all control state and positions and sets end steps to the
//   last step and presets to their defaults at once; per-entry valid bits make
//   every pattern step read as off, so no clearing pass is needed.
module midi_drum_step_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [1:0] channel,
	input  logic [3:0] column,
	input  logic [2:0] preset_sel,
	input  logic       midi_ready,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_addr,
	input  logic [6:0] cfg_data,
	output logic       strobe,
	output logic [7:0] status_byte,
	output logic [6:0] note_key,
	output logic [6:0] note_velocity,
	output logic       last
);
	import mdss_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_TOGGLE, ST_SCAN} state_t;
	typedef enum logic [1:0] {OP_NOTE_ON, OP_NOTE_OFF, OP_STOP} op_t;

	state_t            state_q;
	op_t               op_q;
	logic              ready_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rd_s1;
	logic [CH_W-1:0]   rd_ch_s1;
	logic [ADDR_W-1:0] addr_q;
	logic [1:0]        play_q;
	logic              phase_q;
	logic [6:0]        preset_q [4];
	logic [POS_W-1:0]  pos_q [CHANNELS];
	logic [POS_W-1:0]  end_q [CHANNELS];
	logic              pend_q;
	logic [CH_W-1:0]   pend_ch_q;
	logic [6:0]        pend_vel_q;

	// pattern memory with per-entry valid bits
	logic [7:0]        pattern [DEPTH];
	logic [DEPTH-1:0]  ent_vld_q;
	logic [7:0]        rd_data_q;
	logic              rd_vld_q;

	logic              accept;
	logic              ch_ok;
	logic              col_ok;
	logic [CH_W-1:0]   idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] in_addr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [7:0]        eff;
	logic [POS_W:0]    pos_inc;
	logic [1:0]        psel;
	logic              issue;
	logic              cap_msg;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign ch_ok     = (int'(channel) < CHANNELS);
	assign col_ok    = (int'(column) < STEPS);

	// one channel index serves both the idle event and the walker
	assign idx     = (state_q == ST_IDLE) ? CH_W'(channel) : cnt_q[CH_W-1:0];
	assign in_addr = pat_addr(CH_W'(channel), POS_W'(column));
	assign rd_addr = (state_q == ST_IDLE) ? in_addr : pat_addr(idx, pos_q[idx]);
	assign eff     = rd_vld_q ? rd_data_q : STEP_OFF;
	assign pos_inc = {1'b0, pos_q[idx]} + 1'b1;
	assign psel    = 2'(preset_sel - SEL_PRESET_A);
	assign issue   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(CHANNELS));
	assign cap_msg = rd_s1 && ready_q && ((op_q == OP_STOP) || !eff[7]);

	// memory write port: preset load from idle, inverse in the toggle cycle
	always_comb begin
		we    = 1'b0;
		waddr = in_addr;
		wdata = {1'b0, preset_q[psel]};
		if (state_q == ST_TOGGLE) begin
			we    = 1'b1;
			waddr = addr_q;
			wdata = ~eff;
		end else if (accept && func == FN_PRESS && ch_ok && col_ok &&
				preset_sel >= SEL_PRESET_A && preset_sel <= SEL_PRESET_D) begin
			we = 1'b1;
		end
	end

	// pattern storage and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			pattern[waddr] <= wdata;
		end
		rd_data_q <= pattern[rd_addr];
	end

	// control, state, registers and message output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NOTE_ON;
			ready_q     <= 1'b0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			rd_ch_s1    <= '0;
			addr_q      <= '0;
			play_q      <= PM_STOPPED;
			phase_q     <= 1'b0;
			preset_q[0] <= 7'd0;
			preset_q[1] <= 7'd42;
			preset_q[2] <= 7'd84;
			preset_q[3] <= 7'd127;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= '0;
				end_q[i] <= POS_W'(STEPS - 1);
			end
			pend_q        <= 1'b0;
			pend_ch_q     <= '0;
			pend_vel_q    <= '0;
			ent_vld_q     <= '0;
			rd_vld_q      <= 1'b0;
			strobe        <= 1'b0;
			status_byte   <= '0;
			note_key      <= '0;
			note_velocity <= '0;
			last          <= 1'b0;
		end else begin
			strobe   <= 1'b0;
			rd_vld_q <= ent_vld_q[rd_addr];
			if (we) begin
				ent_vld_q[waddr] <= 1'b1;
			end

			// preset registers
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr)
					REG_PRESET_A: preset_q[0] <= cfg_data;
					REG_PRESET_B: preset_q[1] <= cfg_data;
					REG_PRESET_C: preset_q[2] <= cfg_data;
					REG_PRESET_D: preset_q[3] <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					rd_s1   <= 1'b0;
					ready_q <= midi_ready;
					addr_q  <= in_addr;
					if (accept) begin
						unique case (func)
							FN_TICK: begin
								phase_q <= !phase_q;
								if (!phase_q) begin
									// rising half-beat
									if (play_q != PM_STOPPED) begin
										play_q <= PM_RUNNING;
										if (midi_ready) begin
											op_q    <= OP_NOTE_ON;
											state_q <= ST_SCAN;
										end
									end
								end else if (play_q == PM_RUNNING) begin
									// falling half-beat: off and advance
									op_q    <= OP_NOTE_OFF;
									state_q <= ST_SCAN;
								end
							end
							FN_PLAY: begin
								if (play_q == PM_STOPPED) begin
									play_q <= PM_ARMED;
								end else begin
									play_q <= PM_STOPPED;
									for (int i = 0; i < CHANNELS; i++) begin
										pos_q[i] <= '0;
									end
									if (midi_ready) begin
										op_q    <= OP_STOP;
										state_q <= ST_SCAN;
									end
								end
							end
							FN_PRESS: begin
								if (ch_ok && col_ok && (preset_sel == SEL_TOGGLE ||
										preset_sel > SEL_PRESET_D)) begin
									state_q <= ST_TOGGLE;
								end
							end
							FN_SET_END: begin
								if (ch_ok && col_ok) begin
									end_q[idx] <= POS_W'(column);
									if (pos_q[idx] > POS_W'(column)) begin
										pos_q[idx] <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_TOGGLE: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// issue one channel read per cycle, advancing after the read
					rd_s1    <= issue;
					rd_ch_s1 <= idx;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						if (op_q == OP_NOTE_OFF) begin
							pos_q[idx] <= (pos_inc > {1'b0, end_q[idx]}) ?
								'0 : pos_inc[POS_W-1:0];
						end
					end
					// one message held back so the final one can carry last
					if (cap_msg) begin
						pend_q     <= 1'b1;
						pend_ch_q  <= rd_ch_s1;
						pend_vel_q <= (op_q == OP_NOTE_ON) ? eff[6:0] : 7'd0;
					end
					if ((cap_msg || !rd_s1) && pend_q) begin
						strobe        <= 1'b1;
						status_byte   <= (op_q == OP_NOTE_ON) ? ST_NOTE_ON : ST_NOTE_OFF;
						note_key      <= KEY_BASE + 7'(pend_ch_q);
						note_velocity <= pend_vel_q;
						last          <= !rd_s1;
					end
					if (!rd_s1 && !issue) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/sv/midi_drum_step_sequencer_test.sv
// self-checking testbench for the midi drum step sequencer: drives events and
// preset writes, predicts every midi message and checks each one as it leaves
// depends on mdss_pkg and midi_drum_step_sequencer
module midi_drum_step_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mdss_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 70;

	// selector codes the package leaves unnamed
	localparam logic [2:0] SEL_PRESET_B = 3'd2;
	localparam logic [2:0] SEL_PRESET_C = 3'd3;
	localparam logic [2:0] SEL_SPARE_LO = 3'd5;
	localparam logic [2:0] SEL_SPARE_MID = 3'd6;
	localparam logic [2:0] SEL_SPARE_HI = 3'd7;

	localparam logic [3:0][1:0] PRESET_REGS =
		{REG_PRESET_D, REG_PRESET_C, REG_PRESET_B, REG_PRESET_A};

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] channel;
		logic [3:0] column;
		logic [2:0] sel;
		logic       ready;
	} pad_event_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] key;
		logic [6:0] vel;
		logic       is_last;
	} midi_msg_t;

	// mirror of the sequencer state and the queue of messages it still owes
	class drum_message_scoreboard;
		logic [7:0]       pattern [DEPTH];
		logic [POS_W-1:0] step_pos [CHANNELS];
		logic [POS_W-1:0] end_col [CHANNELS];
		logic [6:0]       preset_vel [4];
		logic [1:0]       mode;
		logic             phase;
		midi_msg_t        due_msgs [$];
		int               errors;

		function new();
			foreach (pattern[i]) pattern[i] = STEP_OFF;
			foreach (step_pos[i]) begin
				step_pos[i] = '0;
				end_col[i] = POS_W'(STEPS - 1);
			end
			preset_vel[0] = 7'd0;
			preset_vel[1] = 7'd42;
			preset_vel[2] = 7'd84;
			preset_vel[3] = 7'd127;
			mode = PM_STOPPED;
			phase = 1'b0;
			errors = 0;
		endfunction

		function void note_preset(logic [1:0] idx, logic [6:0] val);
			preset_vel[idx] = val;
		endfunction

		function logic [7:0] step_at(int ch);
			return pattern[ch * STEPS + int'(step_pos[ch])];
		endfunction

		// work out the messages one accepted event causes
		function void note_event(pad_event_t ev);
			midi_msg_t         msgs [$];
			midi_msg_t         m;
			int                idx;
			logic [POS_W:0]    nxt;
			logic [7:0]        s;
			m.is_last = 1'b0;
			case (ev.func)
				FN_TICK: begin
					phase = ~phase;
					if (phase) begin
						if (mode != PM_STOPPED) begin
							mode = PM_RUNNING;
							if (ev.ready) begin
								for (int i = 0; i < CHANNELS; i++) begin
									s = step_at(i);
									if (!s[7]) begin
										m.status = ST_NOTE_ON;
										m.key = 7'(KEY_BASE + i);
										m.vel = s[6:0];
										msgs.push_back(m);
									end
								end
							end
						end
					end else if (mode > PM_ARMED) begin
						if (ev.ready) begin
							for (int i = 0; i < CHANNELS; i++) begin
								s = step_at(i);
								if (!s[7]) begin
									m.status = ST_NOTE_OFF;
									m.key = 7'(KEY_BASE + i);
									m.vel = 7'd0;
									msgs.push_back(m);
								end
							end
						end
						// advance every channel, wrapping after its end step
						for (int i = 0; i < CHANNELS; i++) begin
							nxt = {1'b0, step_pos[i]} + 1'b1;
							step_pos[i] = (nxt > {1'b0, end_col[i]}) ? '0 : nxt[POS_W-1:0];
						end
					end
				end
				FN_PLAY: begin
					if (mode == PM_STOPPED) begin
						mode = PM_ARMED;
					end else begin
						mode = PM_STOPPED;
						for (int i = 0; i < CHANNELS; i++) begin
							if (ev.ready) begin
								m.status = ST_NOTE_OFF;
								m.key = 7'(KEY_BASE + i);
								m.vel = 7'd0;
								msgs.push_back(m);
							end
							step_pos[i] = '0;
						end
					end
				end
				default: begin
					if (int'(ev.channel) < CHANNELS && int'(ev.column) < STEPS) begin
						idx = int'(ev.channel) * STEPS + int'(ev.column);
						if (ev.func == FN_PRESS) begin
							if (ev.sel >= SEL_PRESET_A && ev.sel <= SEL_PRESET_D)
								pattern[idx] = {1'b0, preset_vel[ev.sel - SEL_PRESET_A]};
							else
								pattern[idx] = ~pattern[idx];
						end else begin
							end_col[ev.channel] = POS_W'(ev.column);
							if (step_pos[ev.channel] > POS_W'(ev.column))
								step_pos[ev.channel] = '0;
						end
					end
				end
			endcase
			if (msgs.size() > 0)
				msgs[msgs.size() - 1].is_last = 1'b1;
			foreach (msgs[i]) due_msgs.push_back(msgs[i]);
		endfunction

		function void report(string name, logic [7:0] want, logic [7:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		endfunction

		// compare one message that left the block with the oldest one owed
		function void check_msg(midi_msg_t got);
			midi_msg_t want;
			if (due_msgs.size() == 0) begin
				errors++;
				$display("%0t: unexpected message, expected none, got %h %h %h %b",
					$time, got.status, got.key, got.vel, got.is_last);
				return;
			end
			want = due_msgs.pop_front();
			if (got.status !== want.status) report("status_byte", want.status, got.status);
			if (got.key !== want.key) report("note_key", 8'(want.key), 8'(got.key));
			if (got.vel !== want.vel) report("note_velocity", 8'(want.vel), 8'(got.vel));
			if (got.is_last !== want.is_last)
				report("last", 8'(want.is_last), 8'(got.is_last));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] func;
	logic [1:0] channel;
	logic [3:0] column;
	logic [2:0] preset_sel;
	logic       midi_ready;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_addr;
	logic [6:0] cfg_data;
	logic       strobe;
	logic [7:0] status_byte;
	logic [6:0] note_key;
	logic [6:0] note_velocity;
	logic       last;

	drum_message_scoreboard sb;
	int  cycle_count;
	bit  no_idle;

	midi_drum_step_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.channel       (channel),
		.column        (column),
		.preset_sel    (preset_sel),
		.midi_ready    (midi_ready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.status_byte   (status_byte),
		.note_key      (note_key),
		.note_velocity (note_velocity),
		.last          (last)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run timed out", $time);
		$display("CHECKS FAILED");
		$finish;
	end

	// every message is taken at the edge that ends its strobe cycle
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			sb.check_msg({status_byte, note_key, note_velocity, last});
	end

	// present one event and hold it until the block takes it
	task automatic drive_event(input pad_event_t ev);
		start <= 1'b1;
		func <= ev.func;
		channel <= ev.channel;
		column <= ev.column;
		preset_sel <= ev.sel;
		midi_ready <= ev.ready;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_event(ev);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// mostly back to back, sometimes a few cycles, now and then a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	// write all four presets, valid held high from one register to the next
	task automatic write_presets(input logic [3:0][6:0] vals);
		for (int r = 0; r < 4; r++) begin
			cfg_valid <= 1'b1;
			cfg_addr <= PRESET_REGS[r];
			cfg_data <= vals[r];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.note_preset(PRESET_REGS[r], vals[r]);
		end
		cfg_valid <= 1'b0;
	endtask

	// wait until every owed message has left, then let the block settle
	task automatic wait_drained();
		int guard;
		guard = 0;
		while (sb.due_msgs.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly ticks and presses while playing, with edits, stops and starts
	function automatic pad_event_t random_event();
		pad_event_t ev;
		int         play_pct;
		int         r;
		ev.channel = 2'($urandom_range(3));
		ev.column = 4'($urandom_range(15));
		ev.sel = 3'($urandom_range(7));
		ev.ready = ($urandom_range(99) < 85);
		play_pct = (sb.mode == PM_STOPPED) ? 30 : 3;
		r = $urandom_range(99);
		if (r < play_pct) begin
			ev.func = FN_PLAY;
		end else begin
			r = $urandom_range(99);
			if (r < 55)
				ev.func = FN_TICK;
			else if (r < 85)
				ev.func = FN_PRESS;
			else
				ev.func = FN_SET_END;
		end
		return ev;
	endfunction

	// directed events: presets, toggles, spare selectors, play, stop, end steps
	task automatic directed_events();
		drive_event('{FN_PRESS, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_PRESS, 2'd1, 4'd0, SEL_PRESET_D, 1'b1});
		drive_event('{FN_PRESS, 2'd2, 4'd0, SEL_PRESET_B, 1'b1});
		drive_event('{FN_PRESS, 2'd3, 4'd0, SEL_SPARE_HI, 1'b0});
		drive_event('{FN_PRESS, 2'd3, 4'd15, SEL_PRESET_C, 1'b1});
		drive_event('{FN_PRESS, 2'd2, 4'd15, SEL_SPARE_LO, 1'b1});
		drive_event('{FN_PRESS, 2'd0, 4'd1, SEL_PRESET_A, 1'b1});
		// ticks while stopped send nothing
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_PLAY, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_TICK, 2'd3, 4'd15, SEL_SPARE_HI, 1'b1});
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		// new end below the position rewinds that channel
		drive_event('{FN_SET_END, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_SET_END, 2'd1, 4'd15, SEL_TOGGLE, 1'b1});
		// link not ready: no messages, positions still move
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b0});
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b0});
		drive_event('{FN_PRESS, 2'd1, 4'd0, SEL_SPARE_MID, 1'b1});
		drive_event('{FN_PRESS, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_TICK, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_PLAY, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_PLAY, 2'd0, 4'd0, SEL_TOGGLE, 1'b1});
		drive_event('{FN_PLAY, 2'd0, 4'd0, SEL_TOGGLE, 1'b0});
		drive_event('{FN_SET_END, 2'd3, 4'd15, SEL_TOGGLE, 1'b1});
	endtask

	// reset, directed events, then random phases under several preset settings
	initial begin
		logic [3:0][6:0] setting;
		sb = new();
		no_idle = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FN_TICK;
		channel <= '0;
		column <= '0;
		preset_sel <= SEL_TOGGLE;
		midi_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr <= REG_PRESET_A;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_events();
		start <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: setting = {7'd0, 7'd127, 7'd0, 7'd127};
				1: setting = {7'd126, 7'd1, 7'd127, 7'd0};
				2: setting = {7'd127, 7'd127, 7'd127, 7'd127};
				3: setting = {7'd0, 7'd0, 7'd0, 7'd0};
				default: begin
					for (int r = 0; r < 4; r++) setting[r] = 7'($urandom_range(127));
				end
			endcase
			write_presets(setting);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 20 == 0)
					no_idle = ($urandom_range(3) == 0);
				idle_cycles(pick_gap());
				drive_event(random_event());
			end
			start <= 1'b0;
			wait_drained();
		end

		if (sb.due_msgs.size() != 0) begin
			sb.errors += sb.due_msgs.size();
			$display("%0t: %0d expected messages never arrived", $time, sb.due_msgs.size());
		end
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/mdss_pkg.sv
rtl/midi_drum_step_sequencer.sv
tb/sv/midi_drum_step_sequencer_test.sv
